// ===== hw/rtl/heating_channel_poll_sequencer_unit_defines.svh =====
// Assertion macros used by the port checker.
`ifndef HEATING_CHANNEL_POLL_SEQUENCER_UNIT_DEFINES_SVH
`define HEATING_CHANNEL_POLL_SEQUENCER_UNIT_DEFINES_SVH
// Assert that an implication holds at every clock edge outside reset.
`define HCPS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert that the consequent holds in the cycle after the antecedent, outside reset.
`define HCPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/hcps_pkg.sv =====
// Package: shared types and constants of the poll sequencer.
package hcps_pkg;
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_SCAN = 3'd1;
    localparam logic [2:0] OP_RESP = 3'd2;
    localparam logic [2:0] OP_NORESP = 3'd3;
    localparam logic [2:0] OP_SETPT = 3'd4;

    localparam logic [2:0] KIND_READ = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_OUTSTAT = 3'd2;
    localparam logic [2:0] KIND_ROOM = 3'd3;
    localparam logic [2:0] KIND_BATT = 3'd4;
    localparam logic [2:0] KIND_TARGET = 3'd5;
    localparam logic [2:0] KIND_MODE = 3'd6;

    localparam logic [7:0] FC_READ = 8'h43;
    localparam logic [7:0] FC_WRITE = 8'h44;

    // Event handed from the front part to the back part.
    typedef struct packed {
        logic [2:0]  opcode;
        logic        response_short;
        logic [7:0]  pay_byte0;
        logic [7:0]  pay_byte1;
        logic [7:0]  pay_byte5;
        logic [7:0]  pay_byte13;
    } evt_t;

    // Setpoint entry: channel and centi value.
    typedef struct packed {
        logic [3:0]  channel;
        logic [13:0] centi;
    } spt_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  channel;
        logic [15:0] value;
        logic [7:0]  func_code;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic        last;
    } res_t;
endpackage

// ===== hw/rtl/hcps_front.sv =====
// Front part: accept events, queue setpoint requests, pass other events on.
module hcps_front #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic [3:0]        sp_channel,
    input  logic [13:0]       sp_centi,
    input  hcps_pkg::evt_t    in_evt,
    output logic              evt_valid,
    input  logic              evt_ready,
    output hcps_pkg::evt_t    evt,
    input  logic              sp_pop,
    output logic              sp_avail,
    output hcps_pkg::spt_t    sp_head
);
    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_C = AW'(FIFO_DEPTH - 1);

    hcps_pkg::spt_t mem [FIFO_DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ev_valid_reg;
    hcps_pkg::evt_t ev_reg;
    logic          is_sp, take, push;
    logic [AW:0]   wsum;
    logic [AW-1:0] waddr;

    // Single event slot; setpoint requests go straight to the FIFO.
    // A tick popping a full FIFO in the same cycle lets a setpoint in.
    assign is_sp = (opcode == hcps_pkg::OP_SETPT);
    assign in_ready = !ev_valid_reg || evt_ready;
    assign take = in_valid && in_ready;
    assign push = take && is_sp && ((count_reg != DEPTH_C) || sp_pop);
    assign wsum = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign waddr = (wsum > (AW+1)'(LAST_C)) ? AW'(wsum - (AW+1)'(FIFO_DEPTH))
                                             : wsum[AW-1:0];

    always_comb begin
        head_next = head_reg;
        count_next = count_reg;
        if (sp_pop) begin
            head_next = (head_reg == LAST_C) ? '0 : head_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(sp_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            count_reg <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            count_reg <= count_next;
            if (take && !is_sp) begin
                ev_valid_reg <= 1'b1;
            end else if (evt_ready) begin
                ev_valid_reg <= 1'b0;
            end
        end
        if (take && !is_sp) begin
            ev_reg <= in_evt;
        end
        if (push) begin
            mem[waddr] <= '{channel: sp_channel, centi: sp_centi};
        end
    end

    assign evt_valid = ev_valid_reg;
    assign evt = ev_reg;
    assign sp_avail = (count_reg != '0);
    assign sp_head = mem[head_reg];
endmodule

// ===== hw/rtl/hcps_back.sv =====
// Back part: poll state machine, response parsing and result output.
module hcps_back #(
    parameter int CHANNELS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       used_channel_mask,
    input  logic              evt_valid,
    output logic              evt_ready,
    input  hcps_pkg::evt_t    evt,
    output logic              sp_pop,
    input  logic              sp_avail,
    input  hcps_pkg::spt_t    sp_head,
    output logic              res_valid,
    input  logic              res_ready,
    output hcps_pkg::res_t    res
);
    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_OUT1, ST_OUT2} state_t;

    state_t state_reg;
    logic busy_reg, scan_reg, have_reg;
    logic [2:0] phase_reg;
    logic [3:0] ch_reg;
    logic [6:0] elem_reg;
    logic       search_first_reg;
    logic       adv_reg;
    hcps_pkg::res_t r0_reg, r1_reg;
    logic [15:0] temp;
    logic [5:0]  el;
    logic [14:0] rnd;
    logic [15:0] tenths;
    logic [8:0]  q;
    logic [13:0] ev;
    logic        ch_used, ch_top;

    assign temp = {evt.pay_byte0, evt.pay_byte1};
    assign el = evt.pay_byte5[5:0];
    // Round centi to 0.5 degree: (c+25)/50 via reciprocal, then *5.
    assign rnd = {1'b0, sp_head.centi} + 15'd25;
    always_comb begin
        logic [31:0] p;
        p = 32'(rnd) * 32'd41944;
        q = p[29:21];
        if (32'(q) * 32'd50 > 32'(rnd)) q = q - 9'd1;
        else if (32'(q + 9'd1) * 32'd50 <= 32'(rnd)) q = q + 9'd1;
    end
    assign tenths = 16'(q) * 16'd5;
    assign ev = {{7{elem_reg[6]}}, elem_reg};
    assign ch_used = (32'(ch_reg) < CHANNELS) && used_channel_mask[ch_reg];
    assign ch_top = (32'(ch_reg) >= CHANNELS - 1);

    assign evt_ready = (state_reg == ST_IDLE);
    assign sp_pop = (state_reg == ST_IDLE) && evt_valid && evt.opcode == hcps_pkg::OP_TICK
                    && !busy_reg && sp_avail && !have_reg;
    assign res_valid = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);
    assign res = (state_reg == ST_OUT2) ? r1_reg : r0_reg;

    function automatic hcps_pkg::res_t rpt(input logic [2:0] k, input logic [3:0] c,
                                           input logic [15:0] v, input logic l);
        rpt = '{kind: k, channel: c, value: v, func_code: 8'h00,
                word_a: 16'h0, word_b: 16'h0, word_c: 16'h0, last: l};
    endfunction

    function automatic hcps_pkg::res_t rdq(input logic [3:0] c, input logic [15:0] a,
                                           input logic [15:0] b);
        rdq = '{kind: hcps_pkg::KIND_READ, channel: c, value: 16'h0,
                func_code: hcps_pkg::FC_READ, word_a: a, word_b: b, word_c: 16'h0,
                last: 1'b1};
    endfunction

    // Emit the read request for the phase in hand.
    function automatic hcps_pkg::res_t rd_for(input logic [2:0] ph, input logic [3:0] c,
                                              input logic [13:0] e);
        unique case (ph)
            3'd1: rd_for = rdq(c, 16'h0300, {4'h0, c, 8'h03});
            3'd2: rd_for = rdq(c, 16'h0104, {e[7:0], 8'h07});
            3'd3: rd_for = rdq(c, 16'h0200, {4'h0, c, 8'h01});
            default: rd_for = rdq(c, 16'h0207, {4'h0, c, 8'h01});
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg <= 1'b0;
            scan_reg <= 1'b0;
            have_reg <= 1'b0;
            phase_reg <= '0;
            ch_reg <= '0;
            elem_reg <= '0;
            search_first_reg <= 1'b0;
            adv_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (evt_valid) begin
                        unique case (evt.opcode)
                            hcps_pkg::OP_TICK: begin
                                if (!busy_reg) begin
                                    if (sp_avail && !have_reg) begin
                                        have_reg <= 1'b1;
                                        ch_reg <= sp_head.channel;
                                        busy_reg <= 1'b1;
                                        r0_reg <= '{kind: hcps_pkg::KIND_WRITE,
                                            channel: sp_head.channel, value: 16'h0,
                                            func_code: hcps_pkg::FC_WRITE,
                                            word_a: 16'h0200,
                                            word_b: {4'h0, sp_head.channel, 8'h01},
                                            word_c: tenths, last: 1'b1};
                                        state_reg <= ST_OUT1;
                                    end else if (scan_reg) begin
                                        scan_reg <= 1'b0;
                                        ch_reg <= '0;
                                        search_first_reg <= 1'b1;
                                        adv_reg <= 1'b0;
                                        state_reg <= ST_SEARCH;
                                    end else if (have_reg) begin
                                        if (phase_reg + 3'd1 > 3'd4) begin
                                            search_first_reg <= 1'b0;
                                            adv_reg <= 1'b1;
                                            state_reg <= ST_SEARCH;
                                        end else begin
                                            phase_reg <= phase_reg + 3'd1;
                                            busy_reg <= 1'b1;
                                            r0_reg <= rd_for(phase_reg + 3'd1, ch_reg, ev);
                                            state_reg <= ST_OUT1;
                                        end
                                    end
                                end
                            end
                            hcps_pkg::OP_SCAN: scan_reg <= 1'b1;
                            hcps_pkg::OP_RESP: begin
                                busy_reg <= 1'b0;
                                if (!evt.response_short) begin
                                    case (phase_reg)
                                        3'd0: have_reg <= 1'b0;
                                        3'd1: begin
                                            elem_reg <= 7'(el) + 7'h7f;
                                            if (el == '0) begin
                                                phase_reg <= 3'd4;
                                            end else begin
                                                if (evt.pay_byte0[1]) phase_reg <= 3'd2;
                                                if (have_reg) begin
                                                    r0_reg <= rpt(hcps_pkg::KIND_OUTSTAT,
                                                        ch_reg, {15'h0, evt.pay_byte1[4]},
                                                        1'b1);
                                                    state_reg <= ST_OUT1;
                                                end
                                            end
                                        end
                                        3'd2: if (have_reg) begin
                                            r0_reg <= rpt(hcps_pkg::KIND_ROOM, ch_reg, temp,
                                                          1'b0);
                                            r1_reg <= rpt(hcps_pkg::KIND_BATT, ch_reg,
                                                16'(evt.pay_byte13) * 16'd10, 1'b1);
                                            state_reg <= ST_OUT1;
                                        end
                                        3'd3: if (have_reg) begin
                                            r0_reg <= rpt(hcps_pkg::KIND_TARGET, ch_reg,
                                                          temp, 1'b1);
                                            state_reg <= ST_OUT1;
                                        end
                                        3'd4: if (have_reg) begin
                                            r0_reg <= rpt(hcps_pkg::KIND_MODE, ch_reg,
                                                {13'h0, evt.pay_byte0[2:0]}, 1'b1);
                                            state_reg <= ST_OUT1;
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            hcps_pkg::OP_NORESP: begin
                                busy_reg <= 1'b0;
                                if (phase_reg == 3'd0) have_reg <= 1'b0;
                                else phase_reg <= 3'd4;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SEARCH: begin
                    // First search tests ch_reg itself; advance searches step past it.
                    if (search_first_reg && ch_used) begin
                        if (!adv_reg && phase_reg == 3'd4) begin
                            // scan landed on a channel whose phases are done: step on
                            adv_reg <= 1'b1;
                            search_first_reg <= 1'b0;
                        end else begin
                            have_reg <= 1'b1;
                            phase_reg <= phase_reg + 3'd1 > 3'd4 ? 3'd1 : phase_reg + 3'd1;
                            busy_reg <= 1'b1;
                            r0_reg <= rd_for(phase_reg + 3'd1 > 3'd4 ? 3'd1
                                                                      : phase_reg + 3'd1,
                                             ch_reg, ev);
                            state_reg <= ST_OUT1;
                        end
                    end else if (ch_top) begin
                        have_reg <= 1'b0;
                        if (adv_reg) phase_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        ch_reg <= ch_reg + 4'd1;
                        search_first_reg <= 1'b1;
                        if (!search_first_reg) begin
                            phase_reg <= 3'd4;
                        end
                    end
                end
                ST_OUT1: if (res_ready) begin
                    state_reg <= r0_reg.last ? ST_IDLE : ST_OUT2;
                end
                ST_OUT2: if (res_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/heating_channel_poll_sequencer_unit.sv =====
// Top level: poll sequencer for a floor-heating controller.
// Events enter on the s_ stream one beat at a time, the opcode on s_tuser;
// setpoint requests are stored in a FIFO at once (dropped when full), other
// events go through a one-entry slot to the poll engine, which emits up to
// two result beats on the m_ stream with the result kind on m_tuser. A tick
// that starts or advances the channel walk searches the mask one channel per
// cycle, and each result beat is held in an output register. Input is held
// off when the slot is full and the poll engine is not idle, as while a
// result beat waits.
module heating_channel_poll_sequencer_unit #(
    parameter int CHANNELS = 16,
    parameter int FIFO_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,        // used_channel_mask
    input  logic        s_tvalid,
    output logic        s_tready,
    // setpoint_channel[3:0] setpoint_centi[17:4] response_short[18]
    // pay_byte0[26:19] pay_byte1[34:27] pay_byte5[42:35] pay_byte13[50:43]
    input  logic [55:0] s_tdata,
    input  logic [2:0]  s_tuser,            // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // channel[3:0] value[19:4] func_code[27:20] word_a[43:28]
    // word_b[59:44] word_c[75:60]
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser,            // kind[2:0]
    output logic        m_tlast
);
    logic [15:0] mask_reg;
    logic evt_valid, evt_ready, sp_pop, sp_avail;
    hcps_pkg::evt_t in_evt, evt;
    hcps_pkg::spt_t sp_head;
    hcps_pkg::res_t res;

    // Hold the channel mask; the user must write it only while idle, the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) mask_reg <= '0;
        else if (cfg_wr_en) mask_reg <= cfg_wr_data;
    end

    assign in_evt = '{opcode: s_tuser, response_short: s_tdata[18],
                      pay_byte0: s_tdata[26:19], pay_byte1: s_tdata[34:27],
                      pay_byte5: s_tdata[42:35], pay_byte13: s_tdata[50:43]};

    hcps_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .opcode(s_tuser), .sp_channel(s_tdata[3:0]), .sp_centi(s_tdata[17:4]),
        .in_evt, .evt_valid, .evt_ready, .evt, .sp_pop, .sp_avail, .sp_head
    );

    hcps_back #(.CHANNELS(CHANNELS)) u_back (
        .aclk, .aresetn, .used_channel_mask(mask_reg), .evt_valid, .evt_ready, .evt,
        .sp_pop, .sp_avail, .sp_head, .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tdata = {4'h0, res.word_c, res.word_b, res.word_a, res.func_code,
                      res.value, res.channel};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule

// ===== hw/rtl/hcps_checker.sv =====
// Port checker for the poll sequencer, bound to the top level.
`include "heating_channel_poll_sequencer_unit_defines.svh"
module hcps_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    `HCPS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")
    `HCPS_ASSERT_IMP(a_kind, aclk, aresetn, m_tvalid, m_tuser != 3'd7, "bad kind")
    `HCPS_ASSERT_IMP(a_req_last, aclk, aresetn, m_tvalid && (m_tuser == hcps_pkg::KIND_READ || m_tuser == hcps_pkg::KIND_WRITE), m_tlast, "request not last")
    `HCPS_ASSERT_NEXT(a_pair, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser == hcps_pkg::KIND_BATT, "room temp without battery")
endmodule

bind heating_channel_poll_sequencer_unit hcps_port_checker u_hcps_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

// ===== bench/hcps_checker.sv =====
// Checker: predicts the poll sequencer's result beats and compares them.
`timescale 1ns / 1ps
module hcps_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          failures,
    output int          pending,
    output int          results_seen
);
    localparam int NCH = 16;
    localparam int DEPTH = 8;

    // Shadow copy of the sequencer state.
    logic [15:0] chan_mask;
    logic        in_flight;
    logic [2:0]  poll_phase;
    int          walk_ch;
    logic [6:0]  elem_idx;
    logic        scan_pending;
    hcps_pkg::spt_t spt_store [DEPTH];
    int          spt_count;
    int          spt_head;

    hcps_pkg::res_t expected_reports [$];

    assign pending = expected_reports.size();

    function automatic hcps_pkg::res_t make_report(logic [2:0] kind, int ch,
                                                   logic [15:0] value);
        hcps_pkg::res_t r;
        r = '0;
        r.kind = kind;
        r.channel = ch[3:0];
        r.value = value;
        return r;
    endfunction

    function automatic hcps_pkg::res_t make_request(logic [2:0] kind, int ch, logic [7:0] fc,
                                                    logic [15:0] a, logic [15:0] b,
                                                    logic [15:0] c);
        hcps_pkg::res_t r;
        r = '0;
        r.kind = kind;
        r.channel = ch[3:0];
        r.func_code = fc;
        r.word_a = a;
        r.word_b = b;
        r.word_c = c;
        return r;
    endfunction

    function automatic bit chan_used(int ch);
        if (ch < 0 || ch >= NCH) return 1'b0;
        return chan_mask[ch];
    endfunction

    // Tick: send a queued setpoint, or issue the next read of the walk.
    task automatic predict_tick(ref hcps_pkg::res_t outs[$]);
        hcps_pkg::spt_t e;
        logic [15:0] tenths;
        logic [15:0] a, b;
        logic [7:0]  ev;
        if (in_flight) return;
        if (spt_count > 0 && walk_ch < 0) begin
            e = spt_store[spt_head];
            tenths = 16'(((32'(e.centi) + 25) / 50) * 5);
            spt_head = (spt_head + 1) % DEPTH;
            spt_count--;
            walk_ch = e.channel;
            outs = {outs, make_request(hcps_pkg::KIND_WRITE, walk_ch, hcps_pkg::FC_WRITE,
                                       16'h0200, {4'h0, e.channel, 8'h01}, tenths)};
            in_flight = 1'b1;
            return;
        end
        if (scan_pending) begin
            scan_pending = 1'b0;
            walk_ch = 0;
            while (walk_ch < NCH && !chan_used(walk_ch)) walk_ch++;
            if (walk_ch >= NCH) begin
                walk_ch = -1;
                return;
            end
        end
        if (walk_ch < 0) return;
        poll_phase = poll_phase + 3'd1;
        if (poll_phase > 3'd4) begin
            do walk_ch++; while (walk_ch < NCH && !chan_used(walk_ch));
            if (walk_ch >= NCH) begin
                poll_phase = 3'd0;
                walk_ch = -1;
                return;
            end
            poll_phase = 3'd1;
        end
        case (poll_phase)
            3'd1: begin a = 16'h0300; b = {4'h0, walk_ch[3:0], 8'h03}; end
            3'd2: begin
                // element index is signed: -1 reads back as 0xFF07
                ev = {elem_idx[6], elem_idx};
                a = 16'h0104;
                b = {ev, 8'h07};
            end
            3'd3: begin a = 16'h0200; b = {4'h0, walk_ch[3:0], 8'h01}; end
            default: begin a = 16'h0207; b = {4'h0, walk_ch[3:0], 8'h01}; end
        endcase
        outs = {outs, make_request(hcps_pkg::KIND_READ, walk_ch, hcps_pkg::FC_READ, a, b,
                                   16'h0000)};
        in_flight = 1'b1;
    endtask

    task automatic predict_response(input logic [55:0] d, ref hcps_pkg::res_t outs[$]);
        logic [7:0]  b0, b1, b5, b13;
        logic [5:0]  el;
        logic [15:0] temp;
        bit          have;
        b0 = d[26:19];
        b1 = d[34:27];
        b5 = d[42:35];
        b13 = d[50:43];
        temp = {b0, b1};
        have = walk_ch >= 0;
        in_flight = 1'b0;
        if (d[18]) return;
        case (poll_phase)
            3'd0: walk_ch = -1;
            3'd1: begin
                el = b5[5:0];
                elem_idx = 7'(el) - 7'd1;
                if (el == 6'd0) begin
                    poll_phase = 3'd4;
                end else begin
                    if (b0[1]) poll_phase = poll_phase + 3'd1;
                    if (have) outs = {outs, make_report(hcps_pkg::KIND_OUTSTAT, walk_ch,
                                                        16'(b1[4]))};
                end
            end
            3'd2: if (have) begin
                outs = {outs, make_report(hcps_pkg::KIND_ROOM, walk_ch, temp)};
                outs = {outs, make_report(hcps_pkg::KIND_BATT, walk_ch, 16'(b13) * 16'd10)};
            end
            3'd3: if (have) outs = {outs, make_report(hcps_pkg::KIND_TARGET, walk_ch, temp)};
            3'd4: if (have) outs = {outs, make_report(hcps_pkg::KIND_MODE, walk_ch,
                                                      16'(b0[2:0]))};
            default: ;
        endcase
    endtask

    task automatic predict_event(input logic [2:0] op, input logic [55:0] d);
        hcps_pkg::res_t outs[$];
        hcps_pkg::spt_t e;
        case (op)
            hcps_pkg::OP_TICK: predict_tick(outs);
            hcps_pkg::OP_SCAN: scan_pending = 1'b1;
            hcps_pkg::OP_RESP: predict_response(d, outs);
            hcps_pkg::OP_NORESP: begin
                in_flight = 1'b0;
                if (poll_phase == 3'd0) walk_ch = -1;
                else poll_phase = 3'd4;
            end
            hcps_pkg::OP_SETPT: if (spt_count < DEPTH) begin
                e.channel = d[3:0];
                e.centi = d[17:4];
                spt_store[(spt_head + spt_count) % DEPTH] = e;
                spt_count++;
            end
            default: ;
        endcase
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) expected_reports = {expected_reports, outs[i]};
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        hcps_pkg::res_t want;
        if (!aresetn) begin
            chan_mask = '0;
            in_flight = 1'b0;
            poll_phase = 3'd0;
            walk_ch = -1;
            elem_idx = '0;
            scan_pending = 1'b0;
            spt_count = 0;
            spt_head = 0;
            failures = 0;
            results_seen = 0;
            expected_reports.delete();
        end else begin
            if (cfg_wr_en) chan_mask = cfg_wr_data;
            if (s_tvalid && s_tready) predict_event(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result beat 0x%0h kind %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    failures++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_tuser));
                    check_field("channel", 16'(want.channel), 16'(m_tdata[3:0]));
                    check_field("value", want.value, m_tdata[19:4]);
                    check_field("func_code", 16'(want.func_code), 16'(m_tdata[27:20]));
                    check_field("word_a", want.word_a, m_tdata[43:28]);
                    check_field("word_b", want.word_b, m_tdata[59:44]);
                    check_field("word_c", want.word_c, m_tdata[75:60]);
                    check_field("last", 16'(want.last), 16'(m_tlast));
                end
            end
        end
    end
endmodule

// ===== bench/heating_channel_poll_sequencer_unit_tb.sv =====
// Testbench top: drives events and mask writes, and gives the verdict.
`timescale 1ns / 1ps
module heating_channel_poll_sequencer_unit_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int failures;
    int pending;
    int results_seen;
    int events_sent;
    int send_gap_pct;
    int recv_stall_pct;

    heating_channel_poll_sequencer_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    hcps_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver side: stall at random at the current rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on run length: well above the slowest legal run.
    initial begin
        #8ms;
        $display("timeout with %0d result beats still expected", pending);
        $display("FAIL heating_channel_poll_sequencer_unit");
        $finish;
    end

    // Pack one event: opcode in bits 2:0, tdata above it; top five bits are padding.
    function automatic logic [58:0] pack_event(logic [2:0] op, logic [3:0] ch,
                                               logic [13:0] centi, logic short_rsp,
                                               logic [7:0] b0, logic [7:0] b1,
                                               logic [7:0] b5, logic [7:0] b13);
        return {5'b00000, b13, b5, b1, b0, short_rsp, centi, ch, op};
    endfunction

    function automatic logic [58:0] rand_response();
        logic [7:0] b5;
        b5 = ($urandom_range(7) == 0) ? {2'($urandom_range(3)), 6'h00}
                                      : 8'($urandom_range(255));
        return pack_event(hcps_pkg::OP_RESP, 4'($urandom), 14'($urandom),
                          ($urandom_range(15) == 0),
                          8'($urandom), 8'($urandom), b5, 8'($urandom));
    endfunction

    // Hold the beat until it is taken; idle first at the sender's rate.
    task automatic send_beat(input logic [58:0] d);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= d[2:0];
        s_tdata <= d[58:3];
        do @(posedge aclk); while (!s_tready);
        events_sent++;
    endtask

    // Write the mask only once the block has drained.
    task automatic write_mask(input logic [15:0] mask);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mask;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed tick/response pairs, with scans, setpoints and noise.
    task automatic random_events(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 38) send_beat(pack_event(hcps_pkg::OP_TICK, 4'($urandom),
                                                14'($urandom), 1'b0,
                                                8'($urandom), 8'($urandom), 8'($urandom),
                                                8'($urandom)));
            else if (roll < 76) send_beat(rand_response());
            else if (roll < 81) send_beat(pack_event(hcps_pkg::OP_NORESP, 4'($urandom),
                                                     14'($urandom),
                                                     1'($urandom), 8'($urandom), 8'($urandom),
                                                     8'($urandom), 8'($urandom)));
            else if (roll < 87) send_beat(pack_event(hcps_pkg::OP_SCAN, 4'($urandom),
                                                     14'($urandom),
                                                     1'($urandom), 8'($urandom), 8'($urandom),
                                                     8'($urandom), 8'($urandom)));
            else if (roll < 97) send_beat(pack_event(hcps_pkg::OP_SETPT, 4'($urandom),
                                                     14'($urandom_range(10000)), 1'($urandom),
                                                     8'($urandom), 8'($urandom), 8'($urandom),
                                                     8'($urandom)));
            else send_beat(pack_event(3'($urandom_range(7, 5)), 4'($urandom), 14'($urandom),
                                      1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        events_sent = 0;
        send_gap_pct = 17;
        recv_stall_pct = 85;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: rounding edges, full FIFO with a drop, start of a mask walk.
        write_mask(16'hFFFF);
        send_beat(pack_event(hcps_pkg::OP_SETPT, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_SETPT, 4'd15, 14'd10000, 1'b0, 8'h00, 8'h00,
                             8'h00, 8'h00));
        send_beat(pack_event(hcps_pkg::OP_SETPT, 4'd3, 14'd24, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_SETPT, 4'd4, 14'd25, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_SETPT, 4'd5, 14'd75, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        repeat (4) send_beat(pack_event(hcps_pkg::OP_SETPT, 4'd9, 14'd8199, 1'b0, 8'h00,
                                        8'h00, 8'h00, 8'h00));
        send_beat(pack_event(hcps_pkg::OP_TICK, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_TICK, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        // response to the write: phase is zero, so the channel is released
        send_beat(pack_event(hcps_pkg::OP_RESP, 4'd0, 14'd0, 1'b0, 8'hFF, 8'hFF, 8'hFF,
                             8'hFF));
        send_beat(pack_event(hcps_pkg::OP_SCAN, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_TICK, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        // reply with element field zero, to a write: phase is zero, so the channel is released
        send_beat(pack_event(hcps_pkg::OP_RESP, 4'd0, 14'd0, 1'b0, 8'h00, 8'hFF, 8'hC0,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_TICK, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_RESP, 4'd0, 14'd0, 1'b1, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(hcps_pkg::OP_TICK, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        // element reply with the all sensors lost bit set: status report, room read skipped
        send_beat(pack_event(hcps_pkg::OP_RESP, 4'd0, 14'd0, 1'b0, 8'h02, 8'h10, 8'h3F,
                             8'hFF));
        send_beat(pack_event(hcps_pkg::OP_NORESP, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00,
                             8'h00));
        send_beat(pack_event(3'd5, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_beat(pack_event(3'd6, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_beat(pack_event(3'd7, 4'd0, 14'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));

        // Random: three idling regimes, two mask settings in each.
        for (int leg = 0; leg < 6; leg++) begin
            case (leg)
                0: write_mask(16'h0000);
                2: write_mask(16'h8001);
                4: write_mask(16'hFFFF);
                default: write_mask(16'($urandom));
            endcase
            if (leg == 2) begin
                send_gap_pct = 85;
                recv_stall_pct = 17;
            end else if (leg == 4) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            random_events(322);
        end
        s_tvalid <= 1'b0;

        // Drain, then let the block settle.
        do @(posedge aclk); while (pending != 0);
        repeat (60) @(posedge aclk);

        $display("covered %0d event beats and %0d result beats over six mask settings",
                 events_sent, results_seen);
        $display("three idling regimes, FIFO overflow, rounding edges, short and empty replies");
        if (failures == 0 && pending == 0) begin
            $display("PASS heating_channel_poll_sequencer_unit");
        end else begin
            $display("FAIL heating_channel_poll_sequencer_unit");
        end
        $finish;
    end
endmodule
